[hdl/fmsv_pkg.sv]
// ----------------------------------------------------------------------------
// fmsv_pkg
// shared constants, types and helpers of the tag=value message validator
// ----------------------------------------------------------------------------
package fmsv_pkg;

   localparam int MaxFieldCount   = 256;
   localparam int MaxMessageBytes = 65536;
   localparam int FcW  = $clog2(MaxFieldCount + 1);
   localparam int OffW = $clog2(MaxMessageBytes + 1);

   localparam logic [7:0] ChEq    = 8'h3D;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [33:0] MagCap   = 34'h080000001;
   localparam logic [33:0] PosLimit = 34'h07FFFFFFF;
   localparam logic [33:0] NegLimit = 34'h080000000;

   typedef enum logic [3:0] {
      ST_OK = 4'd0, ST_BAD_BEGIN = 4'd1, ST_NO_BODYLEN = 4'd2,
      ST_BAD_BODYLEN = 4'd3, ST_LEN_MISMATCH = 4'd4, ST_NO_CKSUM = 4'd5,
      ST_BAD_CKSUM = 4'd6, ST_CKSUM_MISMATCH = 4'd7, ST_FORMAT = 4'd8,
      ST_TOO_MANY = 4'd9, ST_TOO_LONG = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      NS_START, NS_MINUS, NS_DIGITS, NS_STOPPED, NS_BAD
   } num_state_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] tag;
      logic [15:0] voff;
      logic [15:0] vlen;
      logic [3:0]  status;
      logic [8:0]  fields;
      logic [7:0]  cksum;
      logic [31:0] blen;
      logic        run_end;
   } result_type;

   // saturating decimal accumulate
   function automatic logic [33:0] add_digit(input logic [33:0] mag, input logic [7:0] b);
      logic [37:0] t;
      t = {mag, 3'b000} + {2'b00, mag, 1'b0} + {30'd0, b - 8'h30};
      add_digit = (t > {4'd0, MagCap}) ? MagCap : t[33:0];
   endfunction

   function automatic logic mag_fits(input logic neg, input logic [33:0] mag);
      mag_fits = mag <= (neg ? NegLimit : PosLimit);
   endfunction

   function automatic logic [31:0] signed_of(input logic neg, input logic [33:0] mag);
      signed_of = neg ? 32'(-mag) : mag[31:0];
   endfunction

endpackage

[hdl/fmsv_out_buf.sv]
// ----------------------------------------------------------------------------
// fmsv_out_buf
// four-entry result queue between the parser and the result channel
// ----------------------------------------------------------------------------
module fmsv_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_a,
   input  fmsv_pkg::result_type  data_a,
   input  logic                  push_b,
   input  fmsv_pkg::result_type  data_b,
   output logic                  room,
   output logic                  valid,
   input  logic                  ready,
   output fmsv_pkg::result_type  data
);
   fmsv_pkg::result_type q_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff;
   logic       pop;
   logic [1:0] wr2;

   assign valid = cnt_ff != 3'd0;
   // space for the two results one byte can give
   assign room  = cnt_ff <= 3'd2;
   assign data  = q_ff[rd_ff];
   assign pop   = valid && ready;
   assign wr2   = push_a ? wr_ff + 2'd1 : wr_ff;

   always_ff @(posedge clock) begin
      if (push_a) q_ff[wr_ff] <= data_a;
      if (push_b) q_ff[wr2] <= data_b;
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         if (pop) rd_ff <= rd_ff + 2'd1;
         wr_ff <= wr_ff + 2'(push_a) + 2'(push_b);
         cnt_ff <= cnt_ff + 3'(push_a) + 3'(push_b) - 3'(pop);
      end
   end
endmodule

[hdl/fix_message_stream_validator.sv]
// ----------------------------------------------------------------------------
// fix_message_stream_validator
// tag=value message parser and checker, one byte per item
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the result queue holds at most two
// results, so that the field report and final status one byte can give
// always fit; the byte is parsed in the cycle it is accepted and its results
// are queued for the result channel from the next cycle. With the result side
// ready, bytes can follow back to back, the final byte of a message included;
// input is held off only while more than two results wait to be taken.
module fix_message_stream_validator (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // tag,voff,vlen,status,fields,cksum,blen
   output logic         rsp_tuser,   // result_kind
   output logic         rsp_tlast    // run_end
);
   localparam int OW = fmsv_pkg::OffW;
   localparam int FW = fmsv_pkg::FcW;

   logic [7:0]  sep_ff;
   logic        inval_ff, tdig_ff, tneg_ff, tbad_ff, tnb_ff;
   logic [33:0] tacc_ff, nacc_ff;
   logic [FW-1:0] fc_ff;
   logic [OW-1:0] off_ff, fso_ff, vso_ff, bso_ff, beo_ff;
   logic [7:0]  sum_ff, fss_ff, csl_ff, ckv_ff;
   logic        bef_ff, blv_ff, ckvld_ff, nneg_ff;
   logic [31:0] ptag_ff, blen_ff;
   fmsv_pkg::num_state_type ns_ff;
   logic [3:0]  err_ff;

   logic acc, room;
   fmsv_pkg::result_type ra, rb, ro;
   logic pa, pb;

   assign acc = req_tvalid && req_tready;
   assign req_tready = room;

   // next state
   logic        inval_in, tdig_in, tneg_in, tbad_in, tnb_in, nneg_in;
   logic [33:0] tacc_in, nacc_in;
   logic [FW-1:0] fc_in;
   logic [OW-1:0] off_in, fso_in, vso_in, bso_in, beo_in;
   logic [7:0]  sum_in, fss_in, csl_in, ckv_in;
   logic        bef_in, blv_in, ckvld_in, rep;
   logic [31:0] ptag_in, blen_in, tag;
   fmsv_pkg::num_state_type ns_in;
   logic [3:0]  err_in, st;
   logic [7:0]  b;
   logic        dig, nok, complete;
   logic [31:0] nval;
   logic [OW-1:0] p, vlen;
   logic signed [OW:0] actual;

   always_comb begin
      b = req_tdata;
      p = off_ff;
      dig = b >= 8'h30 && b <= 8'h39;
      inval_in = inval_ff; tdig_in = tdig_ff; tneg_in = tneg_ff; tbad_in = tbad_ff;
      tnb_in = tnb_ff; tacc_in = tacc_ff; nacc_in = nacc_ff; nneg_in = nneg_ff;
      ns_in = ns_ff; fc_in = fc_ff; off_in = off_ff; fso_in = fso_ff; vso_in = vso_ff;
      bso_in = bso_ff; beo_in = beo_ff; sum_in = sum_ff; fss_in = fss_ff;
      csl_in = csl_ff; ckv_in = ckv_ff; bef_in = bef_ff; blv_in = blv_ff;
      ckvld_in = ckvld_ff; ptag_in = ptag_ff; blen_in = blen_ff; err_in = err_ff;
      complete = 1'b0; rep = 1'b0;
      tag = fmsv_pkg::signed_of(tneg_ff, tacc_ff);
      nok = (ns_ff == fmsv_pkg::NS_DIGITS || ns_ff == fmsv_pkg::NS_STOPPED)
            && fmsv_pkg::mag_fits(nneg_ff, nacc_ff);
      nval = fmsv_pkg::signed_of(nneg_ff, nacc_ff);
      if (err_ff == 4'd0) begin
         if (off_ff >= OW'(fmsv_pkg::MaxMessageBytes)) err_in = fmsv_pkg::ST_TOO_LONG;
         else begin
            sum_in = sum_ff + b;
            if (inval_ff) begin
               if (b == sep_ff) complete = 1'b1;
               else begin
                  unique case (ns_ff)
                     fmsv_pkg::NS_START: begin
                        if (b == fmsv_pkg::ChMinus) begin
                           nneg_in = 1'b1; ns_in = fmsv_pkg::NS_MINUS;
                        end else if (dig) begin
                           nacc_in = fmsv_pkg::add_digit(nacc_ff, b); ns_in = fmsv_pkg::NS_DIGITS;
                        end else ns_in = fmsv_pkg::NS_BAD;
                     end
                     fmsv_pkg::NS_MINUS: begin
                        if (dig) begin
                           nacc_in = fmsv_pkg::add_digit(nacc_ff, b); ns_in = fmsv_pkg::NS_DIGITS;
                        end else ns_in = fmsv_pkg::NS_BAD;
                     end
                     fmsv_pkg::NS_DIGITS: begin
                        if (dig) nacc_in = fmsv_pkg::add_digit(nacc_ff, b);
                        else ns_in = fmsv_pkg::NS_STOPPED;
                     end
                     default: ;
                  endcase
               end
            end else if (p == fso_ff && fc_ff >= FW'(fmsv_pkg::MaxFieldCount)) begin
               err_in = fmsv_pkg::ST_TOO_MANY;
            end else if (b == fmsv_pkg::ChEq) begin
               if (tbad_ff || !tdig_ff || !fmsv_pkg::mag_fits(tneg_ff, tacc_ff))
                  err_in = fmsv_pkg::ST_FORMAT;
               else begin
                  inval_in = 1'b1;
                  vso_in = p + 1'b1;
                  if (sep_ff == fmsv_pkg::ChEq) complete = 1'b1;
               end
            end else begin
               if (b != sep_ff && b != fmsv_pkg::ChCr && b != fmsv_pkg::ChLf
                   && b != fmsv_pkg::ChSpace) tnb_in = 1'b1;
               if (dig) begin
                  tdig_in = 1'b1; tacc_in = fmsv_pkg::add_digit(tacc_ff, b);
               end else if (b == fmsv_pkg::ChMinus && p == fso_ff) tneg_in = 1'b1;
               else tbad_in = 1'b1;
            end
         end
      end
      // value length from this field's value start (set same cycle when separator is '=')
      vlen = (p >= vso_in) ? p - vso_in : '0;
      if (complete) begin
         if (fc_ff == '0 && tag != 32'd8) err_in = fmsv_pkg::ST_BAD_BEGIN;
         else if (fc_ff == FW'(1) && tag != 32'd9) err_in = fmsv_pkg::ST_NO_BODYLEN;
         else begin
            rep = 1'b1;
            if (fc_ff == FW'(1)) begin
               bso_in = p + 1'b1; blv_in = nok; blen_in = nok ? nval : 32'd0;
            end
            if (tag == 32'd10) begin
               beo_in = fso_ff; bef_in = 1'b1; csl_in = fss_ff;
            end
            ckvld_in = nok && !nval[31] && nval <= 32'd255;
            ckv_in = ckvld_in ? nval[7:0] : 8'd0;
            ptag_in = tag;
            fc_in = fc_ff + 1'b1;
            inval_in = 1'b0; tacc_in = '0; tdig_in = 1'b0; tneg_in = 1'b0;
            tbad_in = 1'b0; tnb_in = 1'b0; ns_in = fmsv_pkg::NS_START;
            nneg_in = 1'b0; nacc_in = '0; fso_in = p + 1'b1; fss_in = sum_in;
         end
      end
      if (off_ff < OW'(fmsv_pkg::MaxMessageBytes)) off_in = off_ff + 1'b1;

      ra = '0;
      ra.tag = tag; ra.voff = 16'(vso_in); ra.vlen = 16'(vlen);
      ra.fields = 9'(fc_in); ra.run_end = !req_tlast;

      actual = $signed({1'b0, beo_in}) - $signed({1'b0, bso_in});
      if (err_in != 4'd0) st = err_in;
      else if (inval_in) st = fmsv_pkg::ST_FORMAT;
      else if (off_in > fso_in && tnb_in) st = fmsv_pkg::ST_FORMAT;
      else if (fc_in < FW'(3)) st = fmsv_pkg::ST_FORMAT;
      else if (ptag_in != 32'd10) st = fmsv_pkg::ST_NO_CKSUM;
      else if (!blv_in) st = fmsv_pkg::ST_BAD_BODYLEN;
      else if (!bef_in) st = fmsv_pkg::ST_FORMAT;
      else if ({{(32-OW-1){actual[OW]}}, actual} != blen_in) st = fmsv_pkg::ST_LEN_MISMATCH;
      else if (!ckvld_in) st = fmsv_pkg::ST_BAD_CKSUM;
      else if (csl_in != ckv_in) st = fmsv_pkg::ST_CKSUM_MISMATCH;
      else st = fmsv_pkg::ST_OK;
      rb = '0;
      rb.kind = 1'b1; rb.tag = ptag_in; rb.status = st; rb.fields = 9'(fc_in);
      rb.cksum = bef_in ? csl_in : 8'd0; rb.blen = blv_in ? blen_in : 32'd0;
      rb.run_end = 1'b1;
   end

   // results go in report-then-status order
   assign pa = acc && (rep || req_tlast);
   assign pb = acc && rep && req_tlast;

   fmsv_out_buf u_buf (
      .clock(clock), .reset(reset),
      .push_a(pa), .data_a(rep ? ra : rb),
      .push_b(pb), .data_b(rb),
      .room(room), .valid(rsp_tvalid), .ready(rsp_tready), .data(ro)
   );

   assign rsp_tdata = {3'd0, ro.blen, ro.cksum, ro.fields, ro.status, ro.vlen, ro.voff,
                       ro.tag};
   assign rsp_tuser = ro.kind;
   assign rsp_tlast = ro.run_end;

   always_ff @(posedge clock) begin
      if (reset) sep_ff <= 8'd1;
      else if (csr_we) sep_ff <= csr_wdata;
      if (reset || (acc && req_tlast)) begin
         inval_ff <= 1'b0; tdig_ff <= 1'b0; tneg_ff <= 1'b0; tbad_ff <= 1'b0;
         tnb_ff <= 1'b0; tacc_ff <= '0; nacc_ff <= '0; nneg_ff <= 1'b0;
         ns_ff <= fmsv_pkg::NS_START; fc_ff <= '0; off_ff <= '0; fso_ff <= '0;
         vso_ff <= '0; bso_ff <= '0; beo_ff <= '0; sum_ff <= '0; fss_ff <= '0;
         csl_ff <= '0; ckv_ff <= '0; bef_ff <= 1'b0; blv_ff <= 1'b0;
         ckvld_ff <= 1'b0; ptag_ff <= '0; blen_ff <= '0; err_ff <= '0;
      end else if (acc) begin
         inval_ff <= inval_in; tdig_ff <= tdig_in; tneg_ff <= tneg_in; tbad_ff <= tbad_in;
         tnb_ff <= tnb_in; tacc_ff <= tacc_in; nacc_ff <= nacc_in; nneg_ff <= nneg_in;
         ns_ff <= ns_in; fc_ff <= fc_in; off_ff <= off_in; fso_ff <= fso_in;
         vso_ff <= vso_in; bso_ff <= bso_in; beo_ff <= beo_in; sum_ff <= sum_in;
         fss_ff <= fss_in; csl_ff <= csl_in; ckv_ff <= ckv_in; bef_ff <= bef_in;
         blv_ff <= blv_in; ckvld_ff <= ckvld_in; ptag_ff <= ptag_in;
         blen_ff <= blen_in; err_ff <= err_in;
      end
   end
endmodule
